/* design/assert_macros.svh */
// Assertion macros shared by the LRU page replacement RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

/* design/lru_pkg.sv */
// Types and constants for the LRU page replacement block.
// Depends on nothing; used by the controller, datapath and top level.
`default_nettype none
package lru_pkg;
    localparam int unsigned PID_W = 4;
    localparam int unsigned PAGE_W = 10;
    localparam int unsigned CNT_W = 11;
    localparam int unsigned STAT_W = 3;
    localparam int unsigned CTR_W = 32;

    typedef enum logic [STAT_W-1:0] {
        ST_CREATED = 3'd0,
        ST_EXISTS = 3'd1,
        ST_BAD_COUNT = 3'd2,
        ST_NO_PROC = 3'd3,
        ST_BAD_PAGE = 3'd4,
        ST_HIT = 3'd5,
        ST_FAULT = 3'd6,
        ST_EVICT = 3'd7
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic lookup;
        logic commit;
        logic cfg_we;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
    } t_stat;
endpackage
`default_nettype wire

/* design/lru_dp.sv */
// Datapath: process table, frame tags, ages, counters and result registers.
// Depends on lru_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lru_dp #(
    parameter int unsigned FRAMES = 16,
    parameter int unsigned PROCS = 16,
    parameter int unsigned MAX_PAGES = 1024
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire lru_pkg::t_cmd i_cmd,
    input  wire logic [4:0] i_cfg_data,
    input  wire logic i_func,
    input  wire logic [lru_pkg::PID_W-1:0] i_pid,
    input  wire logic [lru_pkg::PAGE_W-1:0] i_page_number,
    input  wire logic [lru_pkg::CNT_W-1:0] i_page_count,
    output lru_pkg::t_stat o_stat,
    output logic [lru_pkg::STAT_W-1:0] o_status,
    output logic [lru_pkg::PID_W-1:0] o_evicted_pid,
    output logic [lru_pkg::PAGE_W-1:0] o_evicted_page,
    output logic [4:0] o_frames_used,
    output logic [lru_pkg::CTR_W-1:0] o_hit_count,
    output logic [lru_pkg::CTR_W-1:0] o_fault_count,
    output logic [lru_pkg::CTR_W-1:0] o_replace_count
);
    localparam int unsigned SW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int unsigned AW = $clog2(FRAMES + 1);
    localparam int unsigned PW = (PROCS > 1) ? $clog2(PROCS) : 1;
    localparam logic [lru_pkg::CTR_W-1:0] SAT = '1;
    localparam logic [lru_pkg::CTR_W-1:0] ONE = {{(lru_pkg::CTR_W-1){1'b0}}, 1'b1};

    logic [PROCS-1:0] r_pvalid;
    logic [lru_pkg::CNT_W-1:0] r_ppages [PROCS];
    logic [FRAMES-1:0] r_svalid;
    logic [lru_pkg::PID_W-1:0] r_spid [FRAMES];
    logic [lru_pkg::PAGE_W-1:0] r_spage [FRAMES];
    logic [AW-1:0] r_sage [FRAMES];
    logic [AW-1:0] r_used;
    logic [4:0] r_cap;
    logic [lru_pkg::CTR_W-1:0] r_hits, r_faults, r_evs;

    // Latched item.
    logic r_func;
    logic [lru_pkg::PID_W-1:0] r_pid;
    logic [lru_pkg::PAGE_W-1:0] r_page;
    logic [lru_pkg::CNT_W-1:0] r_count;

    // Lookup results.
    logic r_pid_ok, r_proc_ok, r_hit;
    logic [lru_pkg::CNT_W-1:0] r_plim;
    logic [SW-1:0] r_hslot, r_fslot, r_oslot;
    logic r_done;

    logic [PW-1:0] w_pidx;
    logic w_pid_ok;
    logic [FRAMES-1:0] w_match;
    logic w_hit;
    logic [SW-1:0] w_hslot, w_fslot, w_oslot;
    logic [AW:0] w_cap_eff;

    assign w_pid_ok = (32'(r_pid) < PROCS);
    assign w_pidx = PW'(r_pid);

    // Parallel tag compare and slot searches.
    always_comb begin
        w_hit = 1'b0;
        w_hslot = '0;
        w_fslot = '0;
        w_oslot = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            w_match[i] = r_svalid[i] && (r_spid[i] == r_pid) && (r_spage[i] == r_page);
            if (w_match[i]) begin
                w_hit = 1'b1;
                w_hslot = SW'(i);
            end
            if (!r_svalid[i]) begin
                w_fslot = SW'(i);
            end
            if (r_svalid[i] && (r_sage[i] == r_used - AW'(1))) begin
                w_oslot = SW'(i);
            end
        end
    end

    // Effective capacity is the register clamped to 1..FRAMES.
    always_comb begin
        if (r_cap == 5'd0) begin
            w_cap_eff = (AW+1)'(1);
        end else if (32'(r_cap) > FRAMES) begin
            w_cap_eff = (AW+1)'(FRAMES);
        end else begin
            w_cap_eff = (AW+1)'(r_cap);
        end
    end

    // Control state of the tables and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= '0;
            r_svalid <= '0;
            r_used <= '0;
            r_cap <= 5'd16;
            r_hits <= '0;
            r_faults <= '0;
            r_evs <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.commit;
            if (i_cmd.cfg_we && r_used == '0) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                if (!r_func) begin
                    if (r_count != '0 && 32'(r_count) <= MAX_PAGES && w_pid_ok
                        && !r_pvalid[w_pidx]) begin
                        r_pvalid[w_pidx] <= 1'b1;
                    end
                end else if (r_pid_ok && r_proc_ok && r_page < r_plim) begin
                    if (r_hit) begin
                        if (r_hits != SAT) r_hits <= r_hits + ONE;
                    end else begin
                        if (r_faults != SAT) r_faults <= r_faults + ONE;
                        if ((AW+1)'(r_used) >= w_cap_eff) begin
                            if (r_evs != SAT) r_evs <= r_evs + ONE;
                        end else begin
                            r_svalid[r_fslot] <= 1'b1;
                            r_used <= r_used + AW'(1);
                        end
                    end
                end
            end
        end
    end

    // Payload: item latch, lookup, table writes, ages and results.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_pid <= i_pid;
            r_page <= i_page_number;
            r_count <= i_page_count;
        end
        if (i_cmd.lookup) begin
            r_pid_ok <= w_pid_ok;
            r_proc_ok <= w_pid_ok && r_pvalid[w_pidx];
            r_plim <= r_ppages[w_pidx];
            r_hit <= w_hit;
            r_hslot <= w_hslot;
            r_fslot <= w_fslot;
            r_oslot <= w_oslot;
        end
        if (i_cmd.commit) begin
            o_evicted_pid <= '0;
            o_evicted_page <= '0;
            if (!r_func) begin
                if (r_count == '0 || 32'(r_count) > MAX_PAGES) begin
                    o_status <= lru_pkg::ST_BAD_COUNT;
                end else if (!w_pid_ok) begin
                    o_status <= lru_pkg::ST_NO_PROC;
                end else if (r_pvalid[w_pidx]) begin
                    o_status <= lru_pkg::ST_EXISTS;
                end else begin
                    r_ppages[w_pidx] <= r_count;
                    o_status <= lru_pkg::ST_CREATED;
                end
                o_frames_used <= 5'(r_used);
            end else if (!r_pid_ok || !r_proc_ok) begin
                o_status <= lru_pkg::ST_NO_PROC;
                o_frames_used <= 5'(r_used);
            end else if (r_page >= r_plim) begin
                o_status <= lru_pkg::ST_BAD_PAGE;
                o_frames_used <= 5'(r_used);
            end else if (r_hit) begin
                for (int i = 0; i < FRAMES; i++) begin
                    if (r_svalid[i] && r_sage[i] < r_sage[r_hslot]) begin
                        r_sage[i] <= r_sage[i] + AW'(1);
                    end
                end
                r_sage[r_hslot] <= '0;
                o_status <= lru_pkg::ST_HIT;
                o_frames_used <= 5'(r_used);
            end else if ((AW+1)'(r_used) >= w_cap_eff) begin
                // The reused slot becomes newest; every other resident page ages.
                for (int i = 0; i < FRAMES; i++) begin
                    if (r_svalid[i] && SW'(i) != r_oslot) r_sage[i] <= r_sage[i] + AW'(1);
                end
                r_sage[r_oslot] <= '0;
                r_spid[r_oslot] <= r_pid;
                r_spage[r_oslot] <= r_page;
                o_evicted_pid <= r_spid[r_oslot];
                o_evicted_page <= r_spage[r_oslot];
                o_status <= lru_pkg::ST_EVICT;
                o_frames_used <= 5'(r_used);
            end else begin
                for (int i = 0; i < FRAMES; i++) begin
                    if (r_svalid[i]) r_sage[i] <= r_sage[i] + AW'(1);
                end
                r_sage[r_fslot] <= '0;
                r_spid[r_fslot] <= r_pid;
                r_spage[r_fslot] <= r_page;
                o_status <= lru_pkg::ST_FAULT;
                o_frames_used <= 5'(r_used + AW'(1));
            end
        end
        if (r_done) begin
            o_hit_count <= r_hits;
            o_fault_count <= r_faults;
            o_replace_count <= r_evs;
        end
    end

    assign o_stat.done = r_done;

    `ASSERT_IMPLY(a_used_le_frames, i_clk, i_rst_n, 1'b1, (32'(r_used) <= FRAMES))
    `ASSERT_IMPLY(a_used_count, i_clk, i_rst_n, 1'b1, ($countones(r_svalid) == 32'(r_used)))
    `ASSERT_NEXT(a_done_after_commit, i_clk, i_rst_n, i_cmd.commit, r_done)
endmodule
`default_nettype wire

/* design/lru_ctrl.sv */
// Controller: sequences load, lookup, commit and result handshake.
// Depends on lru_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lru_ctrl (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  wire logic i_stall,
    input  wire logic i_cfg_we,
    input  wire lru_pkg::t_stat i_stat,
    output lru_pkg::t_cmd o_cmd
);
    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_COMMIT, S_WAIT} t_state;
    t_state r_state;
    logic r_ovalid;
    logic w_acc, w_out;

    assign w_out = r_ovalid && !i_stall;
    assign o_stall = (r_state != S_IDLE) || (r_ovalid && i_stall);
    assign w_acc = i_valid && !o_stall;
    assign o_valid = r_ovalid;
    assign o_cmd.load = w_acc;
    assign o_cmd.lookup = (r_state == S_LOOK);
    assign o_cmd.commit = (r_state == S_COMMIT);
    assign o_cmd.cfg_we = i_cfg_we;

    // State and output-valid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (w_out) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_acc) r_state <= S_LOOK;
                end
                S_LOOK: r_state <= S_COMMIT;
                S_COMMIT: r_state <= S_WAIT;
                S_WAIT: begin
                    if (i_stat.done) begin
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_acc, (r_state == S_LOOK))
    `ASSERT_IMPLY(a_no_accept_full, i_clk, i_rst_n, (r_ovalid && i_stall), !w_acc)
endmodule
`default_nettype wire

/* design/lru_page_replacement.sv */
// Top level of the LRU page replacement block: controller plus datapath.
// Depends on lru_pkg, lru_ctrl, lru_dp and assert_macros.svh.
//
//   channel   signals                         direction
//   input     i_valid/o_stall + item fields   in
//   output    o_valid/i_stall + result fields out
//   config    i_cfg_we/i_cfg_data             in
//
// An item is handled in order: latch, parallel tag compare, table update, result load.
// One item is in work at a time; the next is taken in the cycle the held result leaves.
// Reset is synchronous active low, clears valid bits and counters, and sets capacity to 16.
// A stalled result holds; the block accepts no new item while its result is stalled.
`default_nettype none
`include "assert_macros.svh"
module lru_page_replacement #(
    parameter int unsigned FRAMES = 16,
    parameter int unsigned PROCS = 16,
    parameter int unsigned MAX_PAGES = 1024
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic o_stall,
    input  wire logic i_func,
    input  wire logic [lru_pkg::PID_W-1:0] i_pid,
    input  wire logic [lru_pkg::PAGE_W-1:0] i_page_number,
    input  wire logic [lru_pkg::CNT_W-1:0] i_page_count,
    output logic o_valid,
    input  wire logic i_stall,
    output logic [lru_pkg::STAT_W-1:0] o_status,
    output logic [lru_pkg::PID_W-1:0] o_evicted_pid,
    output logic [lru_pkg::PAGE_W-1:0] o_evicted_page,
    output logic [4:0] o_frames_used,
    output logic [lru_pkg::CTR_W-1:0] o_hit_count,
    output logic [lru_pkg::CTR_W-1:0] o_fault_count,
    output logic [lru_pkg::CTR_W-1:0] o_replace_count,
    input  wire logic i_cfg_we,
    input  wire logic [4:0] i_cfg_data
);
    lru_pkg::t_cmd w_cmd;
    lru_pkg::t_stat w_stat;

    lru_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall), .i_cfg_we(i_cfg_we),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    lru_dp #(.FRAMES(FRAMES), .PROCS(PROCS), .MAX_PAGES(MAX_PAGES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_cfg_data(i_cfg_data),
        .i_func(i_func), .i_pid(i_pid), .i_page_number(i_page_number),
        .i_page_count(i_page_count), .o_stat(w_stat), .o_status(o_status),
        .o_evicted_pid(o_evicted_pid), .o_evicted_page(o_evicted_page),
        .o_frames_used(o_frames_used), .o_hit_count(o_hit_count),
        .o_fault_count(o_fault_count), .o_replace_count(o_replace_count)
    );
endmodule
`default_nettype wire
